// ===== sv/pcr_pkg.sv =====
// pcr_pkg: shared types and constants for the partitioned convolution reverb.
// No dependencies.
`timescale 1ns / 1ps
package pcr_pkg;
	localparam int FRAME_DEF = 128;
	localparam int MAX_PARTS_DEF = 8;
	localparam int COEF_DEPTH = 1024;
	localparam int HIST_DEPTH = 2048;
	localparam int CW = 10;
	localparam int HW = 11;
	localparam int LW = 11;
	localparam int SW = 24;
	localparam int ACCW = 58;
	localparam int QDEPTH = 2;

	typedef enum logic {OP_COEF = 1'b0, OP_SAMPLE = 1'b1} op_t;

	typedef struct packed {
		op_t              op;
		logic [CW-1:0]    idx;
		logic signed [SW-1:0] val;
	} item_t;
endpackage

// ===== sv/pcr_front.sv =====
// pcr_front: accepts input beats into a short queue towards the MAC engine.
// Depends on pcr_pkg.
`timescale 1ns / 1ps
module pcr_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  pcr_pkg::item_t  in_item,
	output logic            q_valid,
	output pcr_pkg::item_t  q_item,
	input  logic            q_take
);
	import pcr_pkg::*;
	item_t       mem_q [QDEPTH];
	logic        wr_q, rd_q;
	logic [1:0]  cnt_q;

	assign full = (cnt_q == 2'(QDEPTH));
	assign q_valid = (cnt_q != 2'd0);
	assign q_item = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push && !full) mem_q[wr_q] <= in_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push && !full) wr_q <= ~wr_q;
			if (q_take && q_valid) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push && !full) - 2'(q_take && q_valid);
		end
	end
endmodule

// ===== sv/pcr_back.sv =====
// pcr_back: coefficient and history memories, serial MAC, round/saturate, output register.
// Depends on pcr_pkg.
`timescale 1ns / 1ps
module pcr_back #(
	parameter int FRAME = pcr_pkg::FRAME_DEF,
	parameter int MAX_PARTS = pcr_pkg::MAX_PARTS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [pcr_pkg::LW-1:0]    ir_length,
	input  logic                      q_valid,
	input  pcr_pkg::item_t            q_item,
	output logic                      q_take,
	output logic                      empty,
	input  logic                      pop,
	output logic signed [pcr_pkg::SW-1:0] out_sample
);
	import pcr_pkg::*;
	localparam int CAP0 = MAX_PARTS * FRAME;
	localparam int CAP = (CAP0 > COEF_DEPTH) ? COEF_DEPTH : CAP0;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001, ST_CLR = 6'b000010, ST_MAC = 6'b000100,
		ST_DRAIN = 6'b001000, ST_FIN = 6'b010000, ST_OUT = 6'b100000
	} st_t;
	st_t st_q;

	logic signed [SW-1:0] coef_mem [COEF_DEPTH];
	logic signed [SW-1:0] hist_mem [HIST_DEPTH];
	logic signed [SW-1:0] c_s1, x_s1;
	logic signed [2*SW-1:0] p_s2;
	logic                   v_s1, v_s2;
	logic signed [ACCW-1:0] acc_q;
	logic [HW-1:0] ptr_q, base_q, clr_q;
	logic [LW-1:0] k_q, len_q;
	logic          pass_q;
	logic signed [SW-1:0] res_q;
	logic signed [SW-1:0] out_q;
	logic          full_q;
	logic [LW-1:0] len_c;
	logic signed [ACCW-1:0] t_c;
	logic signed [ACCW-24:0] r_c;

	assign len_c = (ir_length > LW'(CAP)) ? LW'(CAP) : ir_length;
	assign empty = !full_q;
	assign out_sample = out_q;
	assign q_take = (st_q == ST_IDLE) && q_valid;
	assign t_c = acc_q + (ACCW'(1) <<< 22);
	assign r_c = $signed(t_c[ACCW-1:23]); // floor after adding half: rounds half up

	always_ff @(posedge clk) begin
		if (st_q == ST_CLR) begin
			hist_mem[clr_q] <= '0;
			if (clr_q < HW'(COEF_DEPTH)) coef_mem[clr_q[CW-1:0]] <= '0;
		end else if (q_take) begin
			if (q_item.op == OP_COEF) coef_mem[q_item.idx] <= q_item.val;
			else hist_mem[ptr_q] <= q_item.val;
		end
		c_s1 <= coef_mem[k_q[CW-1:0]];
		x_s1 <= hist_mem[base_q - k_q];
		p_s2 <= c_s1 * x_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_CLR; clr_q <= '0; ptr_q <= '0; base_q <= '0;
			k_q <= '0; len_q <= '0; pass_q <= 1'b0; acc_q <= '0;
			v_s1 <= 1'b0; v_s2 <= 1'b0; full_q <= 1'b0; out_q <= '0;
			res_q <= '0;
		end else begin
			v_s1 <= (st_q == ST_MAC);
			v_s2 <= v_s1;
			if (v_s2) acc_q <= acc_q + ACCW'(p_s2);
			// result register refills on the same edge that pops it
			if (st_q == ST_OUT && (!full_q || pop)) full_q <= 1'b1;
			else if (pop && full_q) full_q <= 1'b0;
			unique case (st_q)
				ST_CLR: begin
					clr_q <= clr_q + HW'(1);
					if (clr_q == HW'(HIST_DEPTH - 1)) st_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (q_take && q_item.op == OP_SAMPLE) begin
						base_q <= ptr_q - HW'(FRAME);
						ptr_q <= ptr_q + HW'(1);
						len_q <= len_c;
						pass_q <= (len_c == '0);
						k_q <= '0;
						acc_q <= '0;
						st_q <= (len_c == '0) ? ST_DRAIN : ST_MAC;
					end
				end
				ST_MAC: begin
					k_q <= k_q + LW'(1);
					if (k_q == len_q - LW'(1)) st_q <= ST_DRAIN;
				end
				ST_DRAIN: if (!v_s1 && !v_s2) st_q <= ST_FIN;
				ST_FIN: begin
					if (pass_q) res_q <= x_s1;
					else if (r_c > (ACCW-23)'(8388607)) res_q <= 24'sh7FFFFF;
					else if (r_c < -(ACCW-23)'(8388608)) res_q <= 24'sh800000;
					else res_q <= r_c[SW-1:0];
					st_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!full_q || pop) begin
						out_q <= res_q;
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ===== sv/partitioned_convolution_reverb.sv =====
// Partitioned convolution reverb, direct-form equivalent of uniform overlap-save.
// Items enter through a queue-style push/full port: operation 0 writes a Q1.23
// coefficient at coef_index, operation 1 feeds a Q1.23 audio sample.
// Each audio sample yields one out_sample beat (empty/pop): the convolution of
// the input with the first min(ir_length, MAX_PARTS*FRAME, 1024) taps, taken
// FRAME samples back, rounded and saturated to 24 bits; ir_length 0 passes the
// delayed sample through. Coefficient writes give no result.
// Throughput: one MAC per cycle over a single history/coefficient read port
// while a sample is convolved; the engine takes its next item only when idle,
// which an unpopped result delays; coefficient writes are taken while idle.
// A pushed beat is registered in the input queue before the engine takes it.
// A two-entry input queue lets samples be pushed while the engine works.
// After reset both memories are swept to zero; up to two beats are queued
// meanwhile, then full goes high. The user must write ir_length via cfg_we/
// cfg_data only when idle, unenforced by the block; ir_length resets to zero.
// If the result is not popped the engine finishes the next sample, holds it
// and stalls; the queue then fills and full goes high.
`timescale 1ns / 1ps
module partitioned_convolution_reverb #(
	parameter int FRAME = pcr_pkg::FRAME_DEF,
	parameter int MAX_PARTS = pcr_pkg::MAX_PARTS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [pcr_pkg::LW-1:0]    cfg_data,
	input  logic                      push,
	output logic                      full,
	input  logic                      operation,
	input  logic [pcr_pkg::CW-1:0]    coef_index,
	input  logic signed [pcr_pkg::SW-1:0] value,
	output logic                      empty,
	input  logic                      pop,
	output logic signed [pcr_pkg::SW-1:0] out_sample
);
	import pcr_pkg::*;
	logic [LW-1:0] ir_length_q;
	item_t in_item, q_item;
	logic q_valid, q_take;

	assign in_item.op = op_t'(operation);
	assign in_item.idx = coef_index;
	assign in_item.val = value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ir_length_q <= '0;
		else if (cfg_we) ir_length_q <= cfg_data;
	end

	pcr_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .in_item(in_item),
		.q_valid(q_valid), .q_item(q_item), .q_take(q_take)
	);

	pcr_back #(.FRAME(FRAME), .MAX_PARTS(MAX_PARTS)) u_back (
		.clk(clk), .arst_n(arst_n), .ir_length(ir_length_q), .q_valid(q_valid),
		.q_item(q_item), .q_take(q_take), .empty(empty), .pop(pop),
		.out_sample(out_sample)
	);

`ifndef SYNTHESIS
	a_take_needs_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_take |-> q_valid) else $error("queue read while empty");
	a_full_after_two: assert property (@(posedge clk) disable iff (!arst_n)
		(full && !q_take) |=> full) else $error("queue lost an entry");
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> !empty) else $error("result dropped");
`endif
endmodule

// ===== tb/sv/testbench.sv =====
// testbench: self-checking bench for partitioned_convolution_reverb.
// Needs pcr_pkg and the block; predicts each out_sample from a direct-form
// convolution and compares beats in order.
`timescale 1ns / 1ps
module testbench;
	import pcr_pkg::*;

	localparam int TAP_CAP = (MAX_PARTS_DEF * FRAME_DEF > COEF_DEPTH) ?
		COEF_DEPTH : MAX_PARTS_DEF * FRAME_DEF;
	localparam int DRAIN_CYCLES = 1200;
	localparam logic signed [SW-1:0] S_MAX = 24'sh7fffff;
	localparam logic signed [SW-1:0] S_MIN = -24'sh800000;

	typedef struct {
		op_t                  op;
		logic [CW-1:0]        idx;
		logic signed [SW-1:0] val;
		bit                   fixed;
		logic signed [SW-1:0] want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [LW-1:0] cfg_data = '0;
	logic push = 1'b0;
	logic full;
	logic operation = 1'b0;
	logic [CW-1:0] coef_index = '0;
	logic signed [SW-1:0] value = '0;
	logic empty;
	logic pop = 1'b0;
	logic signed [SW-1:0] out_sample;

	// predictor state
	logic signed [SW-1:0] coef_mem [COEF_DEPTH];
	logic signed [SW-1:0] hist_mem [HIST_DEPTH];
	logic [HW-1:0] hist_ptr = '0;
	logic [LW-1:0] ir_len = '0;

	logic signed [SW-1:0] expected_out [$];
	int errors = 0;
	int idle_left = 0;
	int hold_left = 0;

	always #5 clk = ~clk;

	partitioned_convolution_reverb u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_data(cfg_data),
		.push(push), .full(full),
		.operation(operation), .coef_index(coef_index), .value(value),
		.empty(empty), .pop(pop), .out_sample(out_sample)
	);

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic signed [SW-1:0] convolve_sample(logic signed [SW-1:0] x);
		int taps;
		logic [HW-1:0] base;
		longint acc;
		longint q;
		hist_mem[hist_ptr] = x;
		base = hist_ptr - HW'(FRAME_DEF);
		taps = (ir_len > TAP_CAP) ? TAP_CAP : ir_len;
		hist_ptr = hist_ptr + HW'(1);
		if (taps == 0) return hist_mem[base];
		acc = 0;
		for (int k = 0; k < taps; k++)
			acc += longint'(coef_mem[k]) * longint'(hist_mem[HW'(base - HW'(k))]);
		// round half up, floor shift
		q = (acc + (64'sd1 <<< 22)) >>> 23;
		if (q > 8388607) q = 8388607;
		if (q < -8388608) q = -8388608;
		return q[SW-1:0];
	endfunction

	task automatic send_item(op_t op, logic [CW-1:0] idx, logic signed [SW-1:0] val,
			bit fixed, logic signed [SW-1:0] want);
		int g;
		logic signed [SW-1:0] y;
		@(negedge clk);
		push = 1'b1;
		operation = op;
		coef_index = idx;
		value = val;
		do @(posedge clk); while (full);
		if (op == OP_COEF) begin
			coef_mem[idx] = val;
		end else begin
			y = convolve_sample(val);
			expected_out.insert(expected_out.size(), fixed ? want : y);
		end
		g = gap_len();
		if (g > 0) begin
			@(negedge clk);
			push = 1'b0;
			repeat (g - 1) @(negedge clk);
		end
	endtask

	task automatic drain();
		@(negedge clk);
		push = 1'b0;
		wait (expected_out.size() == 0);
		// coefficient beats give no result; let the engine settle
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic set_length(logic [LW-1:0] len);
		drain();
		cfg_we = 1'b1;
		cfg_data = len;
		@(negedge clk);
		cfg_we = 1'b0;
		ir_len = len;
	endtask

	task automatic random_phase(logic [LW-1:0] len, int n_items, int hold = 0);
		int taps;
		int r;
		op_t op;
		logic [CW-1:0] idx;
		logic signed [SW-1:0] val;
		taps = (len > TAP_CAP) ? TAP_CAP : len;
		set_length(len);
		// long receiver hold-off while items keep coming
		if (hold > 0) hold_left = hold;
		for (int i = 0; i < n_items; i++) begin
			op = ($urandom_range(0, 3) == 0) ? OP_COEF : OP_SAMPLE;
			r = $urandom_range(0, 7);
			val = (r == 0) ? S_MAX : (r == 1) ? S_MIN : (r == 2) ? '0 : SW'($urandom);
			if (taps > 0 && $urandom_range(0, 9) < 7)
				idx = CW'($urandom_range(0, taps - 1));
			else
				idx = CW'($urandom);
			send_item(op, idx, val, 1'b0, '0);
		end
	endtask

	// receiver: random pop gaps, plus a long hold-off on request
	initial begin
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				pop = 1'b0;
				hold_left--;
			end else if (idle_left > 0) begin
				pop = 1'b0;
				idle_left--;
			end else begin
				pop = 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (expected_out.size() == 0) begin
				$display("%0t: unexpected beat, out_sample %0d", $time, out_sample);
				errors++;
			end else begin
				if (out_sample !== expected_out[0]) begin
					$display("%0t: out_sample expected %0d actual %0d",
						$time, expected_out[0], out_sample);
					errors++;
				end
				void'(expected_out.pop_front());
			end
			idle_left = gap_len();
		end
	end

	initial begin
		stim_row_t rows [$];
		for (int i = 0; i < COEF_DEPTH; i++) coef_mem[i] = '0;
		for (int i = 0; i < HIST_DEPTH; i++) hist_mem[i] = '0;
		// history is clear after reset, so early samples come out as zero
		rows = '{
			'{OP_SAMPLE, 10'd0,    S_MAX,     1'b1, 24'sd0},
			'{OP_SAMPLE, 10'd1023, S_MIN,     1'b1, 24'sd0},
			'{OP_COEF,   10'd0,    S_MAX,     1'b0, 24'sd0},
			'{OP_COEF,   10'd1023, S_MIN,     1'b0, 24'sd0},
			'{OP_COEF,   10'd1,    -24'sd1,   1'b0, 24'sd0},
			'{OP_COEF,   10'd2,    24'sd1,    1'b0, 24'sd0},
			'{OP_COEF,   10'h2aa,  24'sh555555, 1'b0, 24'sd0},
			'{OP_COEF,   10'h155,  -24'sh555556, 1'b0, 24'sd0},
			'{OP_SAMPLE, 10'h3ff,  24'sd0,    1'b1, 24'sd0},
			'{OP_SAMPLE, 10'd0,    -24'sd1,   1'b1, 24'sd0},
			'{OP_SAMPLE, 10'd0,    24'sd1,    1'b1, 24'sd0},
			'{OP_SAMPLE, 10'h155,  24'sh555555, 1'b1, 24'sd0},
			'{OP_SAMPLE, 10'h2aa,  -24'sh555556, 1'b1, 24'sd0},
			'{OP_SAMPLE, 10'd0,    S_MAX,     1'b1, 24'sd0},
			'{OP_SAMPLE, 10'd0,    S_MIN,     1'b1, 24'sd0},
			'{OP_COEF,   10'd0,    24'sd0,    1'b0, 24'sd0},
			'{OP_COEF,   10'd1023, 24'sd0,    1'b0, 24'sd0}
		};
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		foreach (rows[i])
			send_item(rows[i].op, rows[i].idx, rows[i].val, rows[i].fixed, rows[i].want);
		random_phase(11'd1, 70);
		random_phase(11'd2, 70);
		random_phase(11'd4, 70, 500);
		random_phase(11'd16, 70);
		random_phase(11'd0, 60);
		random_phase(11'd129, 50);
		random_phase(11'd1024, 14);
		random_phase(11'd2047, 14);
		random_phase(11'd1025, 6);
		random_phase(11'd7, 90);
		random_phase(11'd3, 50);
		drain();
		if (errors == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("testbench: errors");
		$finish;
	end
endmodule

// ===== files.f =====
sv/pcr_pkg.sv
sv/pcr_front.sv
sv/pcr_back.sv
sv/partitioned_convolution_reverb.sv
tb/sv/testbench.sv
